FILE: rtl/two_priority_tx_queue_scheduler_macros.svh
// Assertion macros shared by the transmit queue scheduler.
`ifndef TWO_PRIORITY_TX_QUEUE_SCHEDULER_MACROS_SVH
`define TWO_PRIORITY_TX_QUEUE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tpq_pkg.sv
// Shared constants, types and helpers of the transmit queue scheduler.
package tpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 16;

  localparam int TAG_PORT_BITS = 16;
  localparam int TAG_W         = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
  localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_BITS      = CNT_BITS + 1;

  localparam int LIMIT_BITS  = 6;
  localparam int WEIGHT_BITS = 9;
  localparam int EST_BITS    = 32;
  localparam int PROD_BITS   = EST_BITS + WEIGHT_BITS;
  localparam int ACC_BITS    = PROD_BITS + 1;
  localparam int FRAC_BITS   = 8;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [ACC_BITS-1:0]    ROUND_HALF   = ACC_BITS'(128);
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 6'd63;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 9'd128;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUEUE_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AVERAGE_WEIGHT = 2'd1;

  localparam logic [1:0] CMD_SUBMIT_STD = 2'd0;
  localparam logic [1:0] CMD_SUBMIT_EXP = 2'd1;
  localparam logic [1:0] CMD_SUCCESS    = 2'd2;
  localparam logic [1:0] CMD_FAILURE    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } sched_state_t;

  typedef struct packed {
    logic                   load;
    logic [WEIGHT_BITS-1:0] weight;
    logic [EST_BITS-1:0]    estimate;
    logic [EST_BITS-1:0]    elapsed;
  } ema_req_t;

  // Ring pointer plus offset, wrapped into the queue depth.
  function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] p,
                                                 input logic [CNT_BITS-1:0] n);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(p) + SUM_BITS'(n);
    if (s >= SUM_BITS'(QUEUE_DEPTH)) begin
      s = s - SUM_BITS'(QUEUE_DEPTH);
    end
    return s[PTR_BITS-1:0];
  endfunction

endpackage

FILE: rtl/tpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tpq_ema.sv
// Moving average of send time: registered weighted products and a rounded sum.
module tpq_ema (
  input  logic                         clk,
  input  tpq_pkg::ema_req_t            req,
  output logic [tpq_pkg::EST_BITS-1:0] next_estimate
);

  logic [tpq_pkg::PROD_BITS-1:0] prod_old_r;
  logic [tpq_pkg::PROD_BITS-1:0] prod_new_r;
  logic [tpq_pkg::ACC_BITS-1:0]  sum;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_old_r <= tpq_pkg::PROD_BITS'(req.weight) * tpq_pkg::PROD_BITS'(req.estimate);
      prod_new_r <= tpq_pkg::PROD_BITS'(tpq_pkg::WEIGHT_ONE - req.weight)
                  * tpq_pkg::PROD_BITS'(req.elapsed);
    end
  end

  assign sum = tpq_pkg::ACC_BITS'(prod_old_r) + tpq_pkg::ACC_BITS'(prod_new_r)
             + tpq_pkg::ROUND_HALF;
  assign next_estimate = sum[tpq_pkg::FRAC_BITS +: tpq_pkg::EST_BITS];

endmodule

FILE: rtl/two_priority_tx_queue_scheduler.sv
// Top level of the two-queue strict-priority transmit scheduler.
//
// Two ring queues of packet tags, expedited and standard, live in two one-port-read
// RAMs; at most one tag is in flight, and it stays at the head of its queue until
// its success or failure request arrives. One request is worked on at a time. A
// submit, or an event with nothing in flight, loads its result straight into the
// output register. An event that completes the tag in flight passes through fetch:
// the next head is read via the registered read port of the queue RAMs and the
// moving-average products are registered with it. A new request is taken when not
// in fetch and the output register is empty or being drained. The queue RAMs are
// not cleared after reset; entries are read only once written.
module two_priority_tx_queue_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic [15:0]                        in_entry_tag,
  input  logic [31:0]                        in_now_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_send_valid,
  output logic [15:0]                        out_send_tag,
  output logic                               out_send_expedited,
  output logic                               out_accepted,
  output logic [6:0]                         out_standard_count,
  output logic [31:0]                        out_send_time_estimate,
  input  logic                               cfg_we,
  input  logic [tpq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tpq_pkg::WEIGHT_BITS-1:0]    cfg_wdata
);

  localparam int PB = tpq_pkg::PTR_BITS;
  localparam int CB = tpq_pkg::CNT_BITS;

  tpq_pkg::sched_state_t state_r, state_nxt;

  logic [tpq_pkg::LIMIT_BITS-1:0]  queue_limit_r;
  logic [tpq_pkg::WEIGHT_BITS-1:0] weight_r;
  logic [PB-1:0] exp_head_r, exp_head_nxt, std_head_r, std_head_nxt;
  logic [CB-1:0] exp_cnt_r, exp_cnt_nxt, std_cnt_r, std_cnt_nxt;
  logic          in_flight_r, in_flight_nxt, in_flight_exp_r, in_flight_exp_nxt;
  logic [tpq_pkg::EST_BITS-1:0] start_time_r, start_time_nxt;
  logic [tpq_pkg::EST_BITS-1:0] estimate_r, estimate_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_send_valid_r, out_send_exp_r, out_accepted_r;
  logic [15:0] out_send_tag_r;
  logic [6:0]  out_std_count_r;
  logic [31:0] out_estimate_r;

  logic pend_send_r, pend_exp_r, pend_success_r;
  logic pend_send_nxt, pend_exp_nxt;

  logic in_fire, out_free, out_load, fetch_done, go_fetch, imm_load;
  logic is_submit, sel_exp, push_ok, queues_empty, is_event_hit;
  logic [CB-1:0] sel_cnt;
  logic [PB-1:0] sel_head, push_addr;
  logic imm_send, imm_exp, imm_acc;
  logic [15:0] imm_tag, fetch_tag;
  logic [tpq_pkg::WEIGHT_BITS-1:0] weight_sat;
  logic [tpq_pkg::EST_BITS-1:0]    ema_next;
  logic [tpq_pkg::TAG_W-1:0] exp_rdata, std_rdata;
  tpq_pkg::ema_req_t ema_req;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign is_submit = (in_cmd == tpq_pkg::CMD_SUBMIT_STD) || (in_cmd == tpq_pkg::CMD_SUBMIT_EXP);
  assign sel_exp   = (in_cmd == tpq_pkg::CMD_SUBMIT_EXP);
  assign sel_cnt   = sel_exp ? exp_cnt_r : std_cnt_r;
  assign sel_head  = sel_exp ? exp_head_r : std_head_r;
  assign push_addr = tpq_pkg::ptr_add(sel_head, sel_cnt);
  assign push_ok   = (32'(sel_cnt) <= 32'(queue_limit_r))
                  && (32'(sel_cnt) < 32'(tpq_pkg::QUEUE_DEPTH));
  assign queues_empty = (exp_cnt_r == '0) && (std_cnt_r == '0);
  assign is_event_hit = !is_submit && in_flight_r;
  assign weight_sat   = (weight_r > tpq_pkg::WEIGHT_ONE) ? tpq_pkg::WEIGHT_ONE : weight_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpq_pkg::ST_IDLE: begin
        if (in_fire && is_event_hit) begin
          state_nxt = tpq_pkg::ST_FETCH;
        end
      end
      tpq_pkg::ST_FETCH: begin
        if (out_free) begin
          state_nxt = tpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    fetch_done = 1'b0;
    unique case (state_r)
      tpq_pkg::ST_IDLE:  in_stall = !out_free;
      tpq_pkg::ST_FETCH: fetch_done = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign go_fetch = in_fire && is_event_hit;
  assign imm_load = in_fire && !is_event_hit;
  assign out_load = imm_load || fetch_done;

  always_comb begin
    exp_head_nxt      = exp_head_r;
    std_head_nxt      = std_head_r;
    exp_cnt_nxt       = exp_cnt_r;
    std_cnt_nxt       = std_cnt_r;
    in_flight_nxt     = in_flight_r;
    in_flight_exp_nxt = in_flight_exp_r;
    start_time_nxt    = start_time_r;
    pend_send_nxt     = 1'b0;
    pend_exp_nxt      = 1'b0;
    imm_send          = 1'b0;
    imm_exp           = 1'b0;
    imm_acc           = 1'b0;
    if (in_fire && is_submit && push_ok) begin
      imm_acc = 1'b1;
      if (sel_exp) begin
        exp_cnt_nxt = exp_cnt_r + CB'(1);
      end else begin
        std_cnt_nxt = std_cnt_r + CB'(1);
      end
      if (queues_empty) begin
        imm_send          = 1'b1;
        imm_exp           = sel_exp;
        in_flight_nxt     = 1'b1;
        in_flight_exp_nxt = sel_exp;
        start_time_nxt    = in_now_time;
      end
    end else if (go_fetch) begin
      if (in_flight_exp_r && (exp_cnt_r != '0)) begin
        exp_head_nxt = tpq_pkg::ptr_add(exp_head_r, CB'(1));
        exp_cnt_nxt  = exp_cnt_r - CB'(1);
      end else if (!in_flight_exp_r && (std_cnt_r != '0)) begin
        std_head_nxt = tpq_pkg::ptr_add(std_head_r, CB'(1));
        std_cnt_nxt  = std_cnt_r - CB'(1);
      end
      if (exp_cnt_nxt != '0) begin
        pend_send_nxt = 1'b1;
        pend_exp_nxt  = 1'b1;
      end else if (std_cnt_nxt != '0) begin
        pend_send_nxt = 1'b1;
      end
      in_flight_nxt     = pend_send_nxt;
      in_flight_exp_nxt = pend_exp_nxt;
      if (pend_send_nxt) begin
        start_time_nxt = in_now_time;
      end
    end
  end

  assign ema_req.load     = go_fetch && (in_cmd == tpq_pkg::CMD_SUCCESS);
  assign ema_req.weight   = weight_sat;
  assign ema_req.estimate = estimate_r;
  assign ema_req.elapsed  = in_now_time - start_time_r;

  tpq_ema u_ema (
    .clk           (clk),
    .req           (ema_req),
    .next_estimate (ema_next)
  );

  tpq_ram #(.DEPTH(tpq_pkg::QUEUE_DEPTH), .WIDTH(tpq_pkg::TAG_W)) u_exp_ram (
    .clk   (clk),
    .we    (in_fire && is_submit && push_ok && sel_exp),
    .waddr (push_addr),
    .wdata (in_entry_tag[tpq_pkg::TAG_W-1:0]),
    .re    (go_fetch),
    .raddr (exp_head_nxt),
    .rdata (exp_rdata)
  );

  tpq_ram #(.DEPTH(tpq_pkg::QUEUE_DEPTH), .WIDTH(tpq_pkg::TAG_W)) u_std_ram (
    .clk   (clk),
    .we    (in_fire && is_submit && push_ok && !sel_exp),
    .waddr (push_addr),
    .wdata (in_entry_tag[tpq_pkg::TAG_W-1:0]),
    .re    (go_fetch),
    .raddr (std_head_nxt),
    .rdata (std_rdata)
  );

  assign imm_tag   = imm_send ? 16'(in_entry_tag[tpq_pkg::TAG_W-1:0]) : 16'd0;
  assign fetch_tag = !pend_send_r ? 16'd0 : (pend_exp_r ? 16'(exp_rdata) : 16'(std_rdata));

  assign estimate_nxt  = (fetch_done && pend_success_r) ? ema_next : estimate_r;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= tpq_pkg::ST_IDLE;
      queue_limit_r   <= tpq_pkg::LIMIT_RESET;
      weight_r        <= tpq_pkg::WEIGHT_RESET;
      exp_head_r      <= '0;
      std_head_r      <= '0;
      exp_cnt_r       <= '0;
      std_cnt_r       <= '0;
      in_flight_r     <= 1'b0;
      in_flight_exp_r <= 1'b0;
      start_time_r    <= '0;
      estimate_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      exp_head_r      <= exp_head_nxt;
      std_head_r      <= std_head_nxt;
      exp_cnt_r       <= exp_cnt_nxt;
      std_cnt_r       <= std_cnt_nxt;
      in_flight_r     <= in_flight_nxt;
      in_flight_exp_r <= in_flight_exp_nxt;
      start_time_r    <= start_time_nxt;
      estimate_r      <= estimate_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we && (cfg_index == tpq_pkg::CFG_QUEUE_LIMIT)) begin
        queue_limit_r <= cfg_wdata[tpq_pkg::LIMIT_BITS-1:0];
      end
      if (cfg_we && (cfg_index == tpq_pkg::CFG_AVERAGE_WEIGHT)) begin
        weight_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_fetch) begin
      pend_send_r    <= pend_send_nxt;
      pend_exp_r     <= pend_exp_nxt;
      pend_success_r <= (in_cmd == tpq_pkg::CMD_SUCCESS);
    end
    if (imm_load) begin
      out_send_valid_r <= imm_send;
      out_send_exp_r   <= imm_exp;
      out_send_tag_r   <= imm_tag;
      out_accepted_r   <= imm_acc;
      out_std_count_r  <= 7'(std_cnt_nxt);
      out_estimate_r   <= estimate_r;
    end else if (fetch_done) begin
      out_send_valid_r <= pend_send_r;
      out_send_exp_r   <= pend_send_r && pend_exp_r;
      out_send_tag_r   <= fetch_tag;
      out_accepted_r   <= 1'b1;
      out_std_count_r  <= 7'(std_cnt_r);
      out_estimate_r   <= estimate_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_send_valid         = out_send_valid_r;
  assign out_send_tag           = out_send_tag_r;
  assign out_send_expedited     = out_send_exp_r;
  assign out_accepted           = out_accepted_r;
  assign out_standard_count     = out_std_count_r;
  assign out_send_time_estimate = out_estimate_r;

`include "two_priority_tx_queue_scheduler_macros.svh"

  `TPQ_ASSERT_IMPL(a_flight_has_head, in_flight_r, !queues_empty, "In flight with both queues empty.")
  `TPQ_ASSERT_IMPL(a_fetch_blocks_input, state_r == tpq_pkg::ST_FETCH, in_stall, "Request taken during fetch.")
  `TPQ_ASSERT_NEXT(a_hit_enters_fetch, go_fetch, state_r == tpq_pkg::ST_FETCH, "Event did not fetch.")
  `TPQ_ASSERT_IMPL(a_count_bound, 1'b1, (32'(exp_cnt_r) <= 32'(tpq_pkg::QUEUE_DEPTH)) && (32'(std_cnt_r) <= 32'(tpq_pkg::QUEUE_DEPTH)), "Queue count above depth.")

endmodule
